FILE: src/llcp_pkg.sv
// Shared widths, types and constants for the line-line closest points block.
// Depends on nothing; every other file imports it.
`default_nettype none
package llcp_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int DW = COORD_WIDTH + 1;   // coordinate difference
  localparam int PW = 2 * DW;            // difference product
  localparam int SW = PW + 2;            // dot product
  localparam int HW = SW / 2;            // multiplier slice
  localparam int MW = 2 * SW;            // den, sn, tn
  localparam int QW = COORD_WIDTH + 2;   // quotient bits kept
  localparam int RW = MW + QW + 1;       // remainder
  localparam int NW = DW + MW;           // numerator magnitude

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t MAX_C = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t MIN_C = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam longint SENT_RAW = -64'sd10000 * (64'sd1 <<< FRAC_BITS);
  localparam longint MIN_RAW = -(64'sd1 <<< (COORD_WIDTH - 1));
  localparam coord_t SENTINEL = (SENT_RAW < MIN_RAW) ? MIN_C : coord_t'(SENT_RAW);

  typedef struct packed {
    logic                        par;
    logic signed [MW-1:0]        den;
    logic signed [MW-1:0]        sn;
    logic signed [MW-1:0]        tn;
    logic [2:0][DW-1:0]          d1;
    logic [2:0][DW-1:0]          d2;
    logic [2:0][COORD_WIDTH-1:0] ba;
    logic [2:0][COORD_WIDTH-1:0] bb;
  } front_t;

  typedef struct packed {
    logic          par;
    logic          neg;
    logic [RW-1:0] n;
    logic [MW-1:0] d;
    coord_t        base;
  } lane_t;
endpackage
`default_nettype wire

FILE: src/llcp_if.sv
// Valid/ready word channels for line pairs in and nearest points out.
// Depends on llcp_pkg.
`default_nettype none
interface llcp_in_if;
  import llcp_pkg::*;
  logic valid;
  logic ready;
  coord_t a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z;
  coord_t b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z;
  modport source (output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
                  a_end_z, b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
                  input ready);
  modport sink (input valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
                a_end_z, b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
                output ready);
endinterface

interface llcp_out_if;
  import llcp_pkg::*;
  logic valid;
  logic ready;
  coord_t near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z;
  logic status;
  modport source (output valid, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y,
                  near_b_z, status, input ready);
  modport sink (input valid, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y,
                near_b_z, status, output ready);
endinterface
`default_nettype wire

FILE: src/llcp_front.sv
// Seven-stage front end: differences, dot products, den/sn/tn terms.
// Depends on llcp_pkg.
`default_nettype none
module llcp_front import llcp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_vld,
  input  coord_t pts [12],
  output logic   out_vld,
  output front_t res
);
  typedef struct packed {
    logic                        coll;
    logic [2:0][DW-1:0]          d1;
    logic [2:0][DW-1:0]          d2;
    logic [2:0][COORD_WIDTH-1:0] ba;
    logic [2:0][COORD_WIDTH-1:0] bb;
  } side_t;

  localparam int PA [6] = '{0, 1, 1, 3, 0, 1};
  localparam int PB [6] = '{2, 1, 4, 2, 4, 3};

  logic [6:1] vld;
  side_t side1, side2, side3, side4, side5, side6;
  logic signed [DW-1:0] r1 [3];
  logic signed [PW-1:0] p2 [5][3];
  logic signed [SW-1:0] dot3 [5];
  logic [SW-1:0] mag4 [5];
  logic sgn4 [5];
  logic signed [SW-1:0] aa4, ar4, aa5, ar5, aa6, ar6;
  logic [SW-1:0] pp5 [6][4];
  logic neg5 [6];
  logic signed [MW-1:0] pr6 [6];
  logic signed [MW-1:0] den7, aa7;

  always_comb begin
    den7 = pr6[0] - pr6[1];
    aa7 = MW'(aa6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld <= {vld[5:1], in_vld};
      out_vld <= vld[6];
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        side1.d1[k] <= $signed({pts[3+k][COORD_WIDTH-1], pts[3+k]})
                       - $signed({pts[k][COORD_WIDTH-1], pts[k]});
        side1.d2[k] <= $signed({pts[9+k][COORD_WIDTH-1], pts[9+k]})
                       - $signed({pts[6+k][COORD_WIDTH-1], pts[6+k]});
        r1[k] <= $signed({pts[k][COORD_WIDTH-1], pts[k]})
                 - $signed({pts[6+k][COORD_WIDTH-1], pts[6+k]});
        side1.ba[k] <= pts[k];
        side1.bb[k] <= pts[6+k];
      end
      side1.coll <= (pts[6] == pts[9]) && (pts[7] == pts[10]) && (pts[8] == pts[11]);
      // products for aa, ab, bb, ar, br
      for (int k = 0; k < 3; k++) begin
        p2[0][k] <= $signed(side1.d1[k]) * $signed(side1.d1[k]);
        p2[1][k] <= $signed(side1.d1[k]) * $signed(side1.d2[k]);
        p2[2][k] <= $signed(side1.d2[k]) * $signed(side1.d2[k]);
        p2[3][k] <= $signed(side1.d1[k]) * r1[k];
        p2[4][k] <= $signed(side1.d2[k]) * r1[k];
      end
      side2 <= side1;
      for (int j = 0; j < 5; j++) begin
        dot3[j] <= SW'(p2[j][0]) + SW'(p2[j][1]) + SW'(p2[j][2]);
      end
      side3 <= side2;
      for (int j = 0; j < 5; j++) begin
        mag4[j] <= dot3[j][SW-1] ? SW'(-dot3[j]) : SW'(dot3[j]);
        sgn4[j] <= dot3[j][SW-1];
      end
      aa4 <= dot3[0];
      ar4 <= dot3[3];
      side4 <= side3;
      for (int j = 0; j < 6; j++) begin
        pp5[j][0] <= mag4[PA[j]][HW-1:0] * mag4[PB[j]][HW-1:0];
        pp5[j][1] <= mag4[PA[j]][HW-1:0] * mag4[PB[j]][SW-1:HW];
        pp5[j][2] <= mag4[PA[j]][SW-1:HW] * mag4[PB[j]][HW-1:0];
        pp5[j][3] <= mag4[PA[j]][SW-1:HW] * mag4[PB[j]][SW-1:HW];
        neg5[j] <= sgn4[PA[j]] ^ sgn4[PB[j]];
      end
      aa5 <= aa4;
      ar5 <= ar4;
      side5 <= side4;
      for (int j = 0; j < 6; j++) begin
        pr6[j] <= neg5[j]
          ? -(MW'(pp5[j][0]) + ((MW'(pp5[j][1]) + MW'(pp5[j][2])) << HW)
              + (MW'(pp5[j][3]) << SW))
          : (MW'(pp5[j][0]) + ((MW'(pp5[j][1]) + MW'(pp5[j][2])) << HW)
              + (MW'(pp5[j][3]) << SW));
      end
      aa6 <= aa5;
      ar6 <= ar5;
      side6 <= side5;
      // collapsed second line: project onto the first, or hold the start point
      if (side6.coll) begin
        res.par <= 1'b0;
        res.den <= (aa6 == '0) ? MW'(1) : aa7;
        res.sn <= (aa6 == '0) ? '0 : -MW'(ar6);
        res.tn <= '0;
      end else begin
        res.par <= (den7 == '0);
        res.den <= den7;
        res.sn <= pr6[2] - pr6[3];
        res.tn <= pr6[4] - pr6[5];
      end
      res.d1 <= side6.d1;
      res.d2 <= side6.d2;
      res.ba <= side6.ba;
      res.bb <= side6.bb;
    end
  end
endmodule
`default_nettype wire

FILE: src/llcp_scale.sv
// Three-stage scaling of each direction component by its numerator term.
// Depends on llcp_pkg; feeds six divider lanes.
`default_nettype none
module llcp_scale import llcp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_vld,
  input  front_t fr,
  output logic   out_vld,
  output lane_t  lanes [6]
);
  logic [2:1] vld;
  logic [MW-1:0] num1 [2];
  logic nsg1 [2];
  logic [MW-1:0] den1, den2;
  logic dsg1, par1, par2;
  logic [DW-1:0] dm1 [6];
  logic ds1 [6];
  coord_t base1 [6], base2 [6];
  logic [DW+HW-1:0] pp2 [6][4];
  logic neg2 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld <= {vld[1], in_vld};
      out_vld <= vld[2];
    end
    if (en) begin
      num1[0] <= fr.sn[MW-1] ? MW'(-fr.sn) : MW'(fr.sn);
      num1[1] <= fr.tn[MW-1] ? MW'(-fr.tn) : MW'(fr.tn);
      nsg1[0] <= fr.sn[MW-1];
      nsg1[1] <= fr.tn[MW-1];
      den1 <= fr.den[MW-1] ? MW'(-fr.den) : MW'(fr.den);
      dsg1 <= fr.den[MW-1];
      par1 <= fr.par;
      for (int k = 0; k < 3; k++) begin
        dm1[k] <= fr.d1[k][DW-1] ? DW'(-$signed(fr.d1[k])) : fr.d1[k];
        ds1[k] <= fr.d1[k][DW-1];
        dm1[3+k] <= fr.d2[k][DW-1] ? DW'(-$signed(fr.d2[k])) : fr.d2[k];
        ds1[3+k] <= fr.d2[k][DW-1];
        base1[k] <= fr.ba[k];
        base1[3+k] <= fr.bb[k];
      end
      for (int j = 0; j < 6; j++) begin
        for (int c = 0; c < 4; c++) begin
          pp2[j][c] <= dm1[j] * num1[j / 3][c*HW +: HW];
        end
        neg2[j] <= ds1[j] ^ nsg1[j / 3] ^ dsg1;
      end
      den2 <= den1;
      par2 <= par1;
      base2 <= base1;
      for (int j = 0; j < 6; j++) begin
        lanes[j].n <= RW'(NW'(pp2[j][0]) + (NW'(pp2[j][1]) << HW)
                          + (NW'(pp2[j][2]) << (2*HW)) + (NW'(pp2[j][3]) << (3*HW)));
        lanes[j].neg <= neg2[j];
        lanes[j].d <= den2;
        lanes[j].par <= par2;
        lanes[j].base <= base2[j];
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/llcp_div.sv
// One lane: range check, restoring divide one quotient bit a stage,
// round half away from zero, add to the start point and saturate. Uses llcp_pkg.
`default_nettype none
module llcp_div import llcp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_vld,
  input  lane_t  lane,
  output logic   out_vld,
  output coord_t near,
  output logic   par
);
  localparam logic signed [QW+2:0] HI = (QW+3)'(MAX_C);
  localparam logic signed [QW+2:0] LO = (QW+3)'(MIN_C);

  logic [QW+2:0] vld;
  logic [RW-1:0] rem [QW+1];
  logic [MW-1:0] dv [QW+1];
  logic [QW-1:0] q [QW+1];
  logic ovf [QW+1], neg [QW+1], pr [QW+1];
  coord_t base [QW+1];
  logic [RW-1:0] sub [QW+1];
  logic take [QW+1];
  logic [QW:0] qr;
  logic ovf_r, neg_r, par_r;
  coord_t base_r;
  logic signed [QW+1:0] qs;
  logic signed [QW+2:0] sum;

  always_comb begin
    sub[0] = '0;
    take[0] = 1'b0;
    for (int s = 1; s <= QW; s++) begin
      sub[s] = RW'(dv[s-1]) << (QW - s);
      take[s] = rem[s-1] >= sub[s];
    end
    qs = neg_r ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    sum = (QW+3)'(base_r) + (QW+3)'(qs);
  end

  assign out_vld = vld[QW+2];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[QW+1:0], in_vld};
    if (en) begin
      rem[0] <= lane.n;
      dv[0] <= lane.d;
      q[0] <= '0;
      ovf[0] <= lane.n >= RW'({lane.d, QW'(0)});
      neg[0] <= lane.neg;
      pr[0] <= lane.par;
      base[0] <= lane.base;
      for (int s = 1; s <= QW; s++) begin
        rem[s] <= take[s] ? rem[s-1] - sub[s] : rem[s-1];
        q[s] <= take[s] ? (q[s-1] | (QW'(1) << (QW - s))) : q[s-1];
        dv[s] <= dv[s-1];
        ovf[s] <= ovf[s-1];
        neg[s] <= neg[s-1];
        pr[s] <= pr[s-1];
        base[s] <= base[s-1];
      end
      qr <= (QW+1)'(q[QW]) + (QW+1)'({rem[QW], 1'b0} >= (RW+1)'(dv[QW]));
      ovf_r <= ovf[QW];
      neg_r <= neg[QW];
      par_r <= pr[QW];
      base_r <= base[QW];
      par <= par_r;
      if (par_r) near <= SENTINEL;
      else if (ovf_r) near <= neg_r ? MIN_C : MAX_C;
      else if (sum > HI) near <= MAX_C;
      else if (sum < LO) near <= MIN_C;
      else near <= COORD_WIDTH'(sum);
    end
  end
endmodule
`default_nettype wire

FILE: src/line_line_closest_points_3d_top.sv
// Closest points between two 3D lines given in signed Q16.16 fixed point.
// The block takes one line pair every cycle when the output is not stalled:
// 7 stages form the dot products and the den/sn/tn terms with sliced 34-bit
// multipliers, 3 stages scale each direction, and each of six lanes spends 37
// stages on a range check, a restoring divide of one quotient bit per stage,
// rounding and saturation. A stalled output holds the whole pipeline.
// Parallel lines give status 1 and the -10000.0 sentinel on every axis.
// Depends on llcp_pkg, llcp_if, llcp_front, llcp_scale and llcp_div.
`default_nettype none
module line_line_closest_points_3d_top import llcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  llcp_in_if.sink    req,
  llcp_out_if.source rsp
);
  logic en, f_vld, s_vld;
  coord_t pts [12];
  front_t fr;
  lane_t lanes [6];
  logic d_vld [6];
  coord_t near [6];
  logic par [6];

  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign pts = '{req.a_start_x, req.a_start_y, req.a_start_z,
                 req.a_end_x, req.a_end_y, req.a_end_z,
                 req.b_start_x, req.b_start_y, req.b_start_z,
                 req.b_end_x, req.b_end_y, req.b_end_z};

  llcp_front u_front (.clk, .rst, .en, .in_vld(req.valid), .pts,
                      .out_vld(f_vld), .res(fr));

  llcp_scale u_scale (.clk, .rst, .en, .in_vld(f_vld), .fr,
                      .out_vld(s_vld), .lanes);

  for (genvar j = 0; j < 6; j++) begin : g_lane
    llcp_div u_div (.clk, .rst, .en, .in_vld(s_vld), .lane(lanes[j]),
                    .out_vld(d_vld[j]), .near(near[j]), .par(par[j]));
  end

  assign rsp.valid = d_vld[0];
  assign rsp.near_a_x = near[0];
  assign rsp.near_a_y = near[1];
  assign rsp.near_a_z = near[2];
  assign rsp.near_b_x = near[3];
  assign rsp.near_b_y = near[4];
  assign rsp.near_b_z = near[5];
  assign rsp.status = par[0];
endmodule
`default_nettype wire

FILE: src/llcp_chk.sv
// Port checks for the closest points block, bound to its top level.
// Depends on llcp_pkg and line_line_closest_points_3d_top.
`default_nettype none
module llcp_chk import llcp_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   req_valid,
  input logic   req_ready,
  input logic   rsp_valid,
  input logic   rsp_ready,
  input coord_t nax, nay, naz, nbx, nby, nbz,
  input logic   status
);
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("word out right after reset");

  a_ready_only_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (rsp_valid && !rsp_ready))
    else $error("input held off without an output stall");

  a_sentinel: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status) |-> (nax == SENTINEL && nay == SENTINEL && naz == SENTINEL
      && nbx == SENTINEL && nby == SENTINEL && nbz == SENTINEL))
    else $error("parallel status without sentinel");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(nax) && $stable(nbz)
      && $stable(status)))
    else $error("stalled word changed");
endmodule

bind line_line_closest_points_3d_top llcp_chk u_chk (
  .clk, .rst,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .nax(rsp.near_a_x), .nay(rsp.near_a_y), .naz(rsp.near_a_z),
  .nbx(rsp.near_b_x), .nby(rsp.near_b_y), .nbz(rsp.near_b_z),
  .status(rsp.status)
);
`default_nettype wire
